// File: hw/rtl/lso_pkg.sv
// Shared types, constants and codes of the lidar sector obstacle steering block.
package lso_pkg;

  localparam int SamplesPerScan = 360;
  localparam int IdxW = 9;
  localparam int CntW = 9;
  localparam int SumW = 25;
  localparam int RangeW = 16;
  localparam int WidthW = 7;
  localparam int CfgW = 16;
  localparam int BndW = 11;
  localparam int QueueDepth = 2;
  localparam int QPtrW = 1;
  localparam int QCntW = 2;
  localparam int StepW = 5;

  localparam logic [IdxW-1:0] IdxMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam logic [StepW-1:0] LastStep = StepW'(SumW - 1);

  localparam logic CFG_SECTOR_WIDTH = 1'b0;
  localparam logic CFG_OBSTACLE_MM = 1'b1;

  localparam logic [1:0] STEER_STRAIGHT = 2'd0;
  localparam logic [1:0] STEER_TURN = 2'd1;
  localparam logic [1:0] STEER_LEFT = 2'd2;
  localparam logic [1:0] STEER_RIGHT = 2'd3;

  localparam logic [WidthW-1:0] SectorWidthRst = WidthW'(30);
  localparam logic [RangeW-1:0] ObstacleMmRst = RangeW'(300);

  typedef struct packed {
    logic [SumW-1:0] sum_front;
    logic [SumW-1:0] sum_right;
    logic [SumW-1:0] sum_left;
    logic [CntW-1:0] count_front;
    logic [CntW-1:0] count_right;
    logic [CntW-1:0] count_left;
  } scan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// File: hw/rtl/lso_front.sv
// Front part: tracks the angle index and accumulates sector sums and counts.
module lso_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lso_pkg::RangeW-1:0]    range_mm_i,
  input  logic                          range_finite_i,
  input  logic                          last_of_scan_i,
  input  logic [lso_pkg::WidthW-1:0]    sector_width_i,
  input  lso_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output lso_pkg::scan_t                push_data_o
);
  import lso_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  scan_t acc_q, acc_d, acc_new;
  logic accept;
  logic signed [BndW-1:0] i_s, w_s, n_s, w3_s;
  logic in_front, in_right, in_left;

  assign in_stall_o = q_status_i.full;
  assign accept = in_valid_i & ~q_status_i.full;

  assign i_s = signed'(BndW'(idx_q));
  assign w_s = signed'(BndW'(sector_width_i));
  assign n_s = signed'(BndW'(SamplesPerScan));
  assign w3_s = (w_s <<< 1) + w_s;

  assign in_front = (i_s <= w_s) || (i_s >= n_s - w_s);
  assign in_right = (n_s - w3_s <= i_s) && (i_s <= n_s - w_s);
  assign in_left = (w_s < i_s) && (i_s <= w3_s);

  always_comb begin
    acc_new = acc_q;
    if (range_finite_i) begin
      if (in_front && acc_q.count_front != CntMax) begin
        acc_new.sum_front = acc_q.sum_front + SumW'(range_mm_i);
        acc_new.count_front = acc_q.count_front + 1'b1;
      end
      if (in_right && acc_q.count_right != CntMax) begin
        acc_new.sum_right = acc_q.sum_right + SumW'(range_mm_i);
        acc_new.count_right = acc_q.count_right + 1'b1;
      end
      if (in_left && acc_q.count_left != CntMax) begin
        acc_new.sum_left = acc_q.sum_left + SumW'(range_mm_i);
        acc_new.count_left = acc_q.count_left + 1'b1;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    acc_d = acc_q;
    if (accept) begin
      if (last_of_scan_i) begin
        idx_d = '0;
        acc_d = '0;
      end else begin
        acc_d = acc_new;
        if (idx_q != IdxMax) begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  assign push_o = accept & last_of_scan_i;
  assign push_data_o = acc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      acc_q <= '0;
    end else begin
      idx_q <= idx_d;
      acc_q <= acc_d;
    end
  end

endmodule

// File: hw/rtl/lso_queue.sv
// Two-entry queue of finished scan totals between the front and back parts.
module lso_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  lso_pkg::scan_t     push_data_i,
  input  logic               pop_i,
  output lso_pkg::scan_t     pop_data_o,
  output lso_pkg::q_status_t status_o
);
  import lso_pkg::*;

  scan_t mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign status_o.full = (cnt_q == QCntW'(QueueDepth));
  assign status_o.empty = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i) else $error("push into full scan queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i) else $error("pop from empty scan queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth)) else $error("scan queue count out of range");
`endif

endmodule

// File: hw/rtl/lso_back.sv
// Back part: divides the sector totals bit by bit and decides obstacle and steering.
module lso_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lso_pkg::q_status_t          q_status_i,
  input  lso_pkg::scan_t              pop_data_i,
  output logic                        pop_o,
  input  logic [lso_pkg::RangeW-1:0]  obstacle_mm_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lso_pkg::RangeW-1:0]  avg_front_o,
  output logic [lso_pkg::RangeW-1:0]  avg_right_o,
  output logic [lso_pkg::RangeW-1:0]  avg_left_o,
  output logic                        obstacle_o,
  output logic [1:0]                  steer_code_o
);
  import lso_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;
  logic [StepW-1:0] step_q;
  logic [SumW-1:0] quo_q [3];
  logic [CntW-1:0] rem_q [3];
  logic [CntW-1:0] den_q [3];
  logic [SumW-1:0] quo_d [3];
  logic [CntW-1:0] rem_d [3];
  logic [RangeW-1:0] avg [3];
  logic [RangeW-1:0] mn, mx, mn01, mx01;
  logic obst;
  logic [1:0] steer;
  logic out_free, load_out;
  logic out_valid_q;
  logic [RangeW-1:0] avg_front_q, avg_right_q, avg_left_q;
  logic obstacle_q;
  logic [1:0] steer_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [CntW:0] trial;
      trial = {rem_q[k], quo_q[k][SumW-1]};
      if (trial >= {1'b0, den_q[k]}) begin
        rem_d[k] = CntW'(trial - {1'b0, den_q[k]});
        quo_d[k] = {quo_q[k][SumW-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[CntW-1:0];
        quo_d[k] = {quo_q[k][SumW-2:0], 1'b0};
      end
      avg[k] = (den_q[k] == '0) ? '0 : quo_q[k][RangeW-1:0];
    end
  end

  assign mn01 = (avg[0] < avg[1]) ? avg[0] : avg[1];
  assign mn = (mn01 < avg[2]) ? mn01 : avg[2];
  assign mx01 = (avg[0] > avg[1]) ? avg[0] : avg[1];
  assign mx = (mx01 > avg[2]) ? mx01 : avg[2];
  assign obst = (mn != '0) && (mn < obstacle_mm_i);

  always_comb begin
    if (!obst) begin
      steer = STEER_STRAIGHT;
    end else if (mx == avg[0]) begin
      steer = STEER_TURN;
    end else if (mx == avg[2]) begin
      steer = STEER_LEFT;
    end else begin
      steer = STEER_RIGHT;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o = (state_q == ST_IDLE) && !q_status_i.empty;
  assign load_out = (state_q == ST_DONE) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quo_q[0] <= pop_data_i.sum_front;
      quo_q[1] <= pop_data_i.sum_right;
      quo_q[2] <= pop_data_i.sum_left;
      den_q[0] <= pop_data_i.count_front;
      den_q[1] <= pop_data_i.count_right;
      den_q[2] <= pop_data_i.count_left;
      for (int k = 0; k < 3; k++) begin
        rem_q[k] <= '0;
      end
    end else if (state_q == ST_DIV) begin
      for (int k = 0; k < 3; k++) begin
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
    if (load_out) begin
      avg_front_q <= avg[0];
      avg_right_q <= avg[1];
      avg_left_q <= avg[2];
      obstacle_q <= obst;
      steer_q <= steer;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV && step_q != LastStep) begin
        step_q <= step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign avg_front_o = avg_front_q;
  assign avg_right_o = avg_right_q;
  assign avg_left_o = avg_left_q;
  assign obstacle_o = obstacle_q;
  assign steer_code_o = steer_q;

`ifndef SYNTHESIS
  a_steer_obst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> ((steer_code_o == STEER_STRAIGHT) == !obstacle_o))
    else $error("steering code disagrees with obstacle flag");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_DIV |-> step_q == '0) else $error("divider step count runs outside division");
  a_quo_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (den_q[0] == '0 || quo_q[0][SumW-1:RangeW] == '0))
    else $error("front average exceeds range width");
`endif

endmodule

// File: hw/rtl/lidar_sector_obstacle_steer.sv
// Top level of the lidar sector obstacle steering block with its configuration registers.
// Samples are taken one per cycle while the queue is not full; accumulation of a sample
// completes in the cycle it transfers. After the last sample of a scan, its totals enter the
// queue; the bit-serial divider (three lanes in parallel) runs, then the decision is registered.
// Up to two finished scans wait in the queue; the input stalls only while it is full.
// Reset clears the index, the accumulators and the queue, and loads width 30 and threshold 300.
module lidar_sector_obstacle_steer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [lso_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lso_pkg::RangeW-1:0]  range_mm_i,
  input  logic                        range_finite_i,
  input  logic                        last_of_scan_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lso_pkg::RangeW-1:0]  avg_front_o,
  output logic [lso_pkg::RangeW-1:0]  avg_right_o,
  output logic [lso_pkg::RangeW-1:0]  avg_left_o,
  output logic                        obstacle_o,
  output logic [1:0]                  steer_code_o
);
  import lso_pkg::*;

  logic [WidthW-1:0] sector_width_q;
  logic [RangeW-1:0] obstacle_mm_q;
  logic push, pop;
  scan_t push_data, pop_data;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sector_width_q <= SectorWidthRst;
      obstacle_mm_q <= ObstacleMmRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SECTOR_WIDTH: sector_width_q <= cfg_data_i[WidthW-1:0];
        CFG_OBSTACLE_MM: obstacle_mm_q <= cfg_data_i[RangeW-1:0];
        default: ;
      endcase
    end
  end

  lso_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .range_mm_i     (range_mm_i),
    .range_finite_i (range_finite_i),
    .last_of_scan_i (last_of_scan_i),
    .sector_width_i (sector_width_q),
    .q_status_i     (q_status),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  lso_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  lso_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_status_i    (q_status),
    .pop_data_i    (pop_data),
    .pop_o         (pop),
    .obstacle_mm_i (obstacle_mm_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .avg_front_o   (avg_front_o),
    .avg_right_o   (avg_right_o),
    .avg_left_o    (avg_left_o),
    .obstacle_o    (obstacle_o),
    .steer_code_o  (steer_code_o)
  );

endmodule
